### rtl/kbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbf_pkg
// Shared constants, register indexes and control types of the angle/bias
// kalman filter.
// ----------------------------------------------------------------------------
package kbf_pkg;

    localparam int CHANNELS_DEF  = 2;
    localparam int WORD_BITS_DEF = 32;

    localparam int IO_BITS       = 32;   // angle, rate and result words
    localparam int TS_BITS       = 24;   // time step, unsigned q1.23
    localparam int CFG_BITS      = 32;
    localparam int CFG_IDX_BITS  = 2;
    localparam int FRAC_DT       = 23;
    localparam int FRAC_GAIN     = 24;
    localparam int IN_DATA_BITS  = 2 * IO_BITS + TS_BITS;
    localparam int OUT_DATA_BITS = 2 * IO_BITS;
    localparam int IN_USER_BITS  = 2;
    localparam int OUT_USER_BITS = 2;

    localparam logic [TS_BITS-1:0] ONE_SECOND = 24'h800000;

    localparam logic [CFG_BITS-1:0] Q_ANGLE_RST    = 32'd16777;
    localparam logic [CFG_BITS-1:0] Q_BIAS_RST     = 32'd50332;
    localparam logic [CFG_BITS-1:0] MEAS_NOISE_RST = 32'd503316;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_Q_ANGLE    = 2'd0,
        CFG_Q_BIAS     = 2'd1,
        CFG_MEAS_NOISE = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic start;
        logic sh24;     // shift by the gain fraction, else by the dt fraction
    } t_mul_ctl;

endpackage

### rtl/kbf_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbf_mul
// Bit-serial shift-add multiplier with rounding half away from zero,
// right shift by 23 or 24 bits and saturation to the word.
// ----------------------------------------------------------------------------
module kbf_mul #(
    parameter  int WORD_BITS = kbf_pkg::WORD_BITS_DEF,
    localparam int OW        = ((WORD_BITS > 32) ? WORD_BITS : 32) + 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  kbf_pkg::t_mul_ctl           i_ctl,
    input  logic signed [OW-1:0]        i_a,
    input  logic signed [OW-1:0]        i_b,
    output logic                        o_done,
    output logic signed [WORD_BITS-1:0] o_result
);

    localparam int PW = 2 * OW;
    localparam int CW = $clog2(OW);
    localparam logic [PW-1:0] RND23   = PW'(1) << (kbf_pkg::FRAC_DT - 1);
    localparam logic [PW-1:0] RND24   = PW'(1) << (kbf_pkg::FRAC_GAIN - 1);
    localparam logic [PW-1:0] MAG_MAX = (PW'(1) << (WORD_BITS - 1)) - PW'(1);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_RND, S_SAT} t_state;

    t_state                 r_state;
    logic [CW-1:0]          r_cnt;
    logic [OW-1:0]          r_mcand;
    logic [PW-1:0]          r_prod;
    logic                   r_neg;
    logic                   r_sh24;
    logic                   r_done;
    logic signed [WORD_BITS-1:0] r_result;

    logic [OW-1:0] w_ua;
    logic [OW-1:0] w_ub;
    logic [OW:0]   w_sum;
    logic [PW-1:0] w_rnd;
    logic [PW-1:0] w_shr;

    assign w_ua  = i_a[OW-1] ? $unsigned(-i_a) : $unsigned(i_a);
    assign w_ub  = i_b[OW-1] ? $unsigned(-i_b) : $unsigned(i_b);
    assign w_sum = {1'b0, r_prod[PW-1:OW]} + (r_prod[0] ? {1'b0, r_mcand} : '0);
    assign w_rnd = r_prod + (r_sh24 ? RND24 : RND23);
    assign w_shr = r_sh24 ? (w_rnd >> kbf_pkg::FRAC_GAIN) : (w_rnd >> kbf_pkg::FRAC_DT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_ctl.start) begin
                        r_mcand <= w_ua;
                        r_prod  <= {{OW{1'b0}}, w_ub};
                        r_neg   <= i_a[OW-1] ^ i_b[OW-1];
                        r_sh24  <= i_ctl.sh24;
                        r_cnt   <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_prod <= {w_sum, r_prod[OW-1:1]};
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == CW'(OW - 1)) begin
                        r_state <= S_RND;
                    end
                end
                S_RND: begin
                    r_prod  <= w_shr;
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    if (r_prod > MAG_MAX) begin
                        r_result <= r_neg ? {1'b1, {(WORD_BITS-1){1'b0}}}
                                          : {1'b0, {(WORD_BITS-1){1'b1}}};
                    end else begin
                        r_result <= r_neg ? -$signed(r_prod[WORD_BITS-1:0])
                                          : $signed(r_prod[WORD_BITS-1:0]);
                    end
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

### rtl/kbf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbf_div
// Restoring divider, one quotient bit per cycle: n / d with 24 fraction
// bits, truncated toward zero and saturated to the word.
// ----------------------------------------------------------------------------
module kbf_div #(
    parameter int WORD_BITS = kbf_pkg::WORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic signed [WORD_BITS-1:0] i_num,
    input  logic signed [WORD_BITS-1:0] i_den,
    output logic                        o_done,
    output logic signed [WORD_BITS-1:0] o_quot
);

    localparam int W  = WORD_BITS;
    localparam int DW = W + kbf_pkg::FRAC_GAIN;
    localparam int CW = $clog2(DW);
    localparam logic [DW-1:0] MAG_MAX = (DW'(1) << (W - 1)) - DW'(1);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_SAT} t_state;

    t_state          r_state;
    logic [CW-1:0]   r_cnt;
    logic [DW-1:0]   r_q;
    logic [W-1:0]    r_rem;
    logic [W-1:0]    r_ud;
    logic            r_neg;
    logic            r_done;
    logic signed [W-1:0] r_quot;

    logic [W-1:0] w_un;
    logic [W-1:0] w_ud;
    logic [W:0]   w_sh;
    logic [W:0]   w_diff;
    logic         w_ge;

    assign w_un   = i_num[W-1] ? $unsigned(-i_num) : $unsigned(i_num);
    assign w_ud   = i_den[W-1] ? $unsigned(-i_den) : $unsigned(i_den);
    assign w_sh   = {r_rem, r_q[DW-1]};
    assign w_ge   = (w_sh >= {1'b0, r_ud});
    assign w_diff = w_sh - {1'b0, r_ud};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_q     <= {w_un, {kbf_pkg::FRAC_GAIN{1'b0}}};
                        r_rem   <= '0;
                        r_ud    <= w_ud;
                        r_neg   <= i_num[W-1] ^ i_den[W-1];
                        r_cnt   <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_rem  <= w_ge ? w_diff[W-1:0] : w_sh[W-1:0];
                    r_q    <= {r_q[DW-2:0], w_ge};
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == CW'(DW - 1)) begin
                        r_state <= S_SAT;
                    end
                end
                S_SAT: begin
                    if (r_q > MAG_MAX) begin
                        r_quot <= r_neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
                    end else begin
                        r_quot <= r_neg ? -$signed(r_q[W-1:0]) : $signed(r_q[W-1:0]);
                    end
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

### rtl/angle_bias_kalman_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angle_bias_kalman_filter
// Two-state (angle, gyro bias) kalman filter per channel, sequenced over a
// bit-serial multiplier and a bit-serial divider.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one item per transaction: tuser = {channel, kind},
//   tdata = {time_step, measured_rate, measured_angle}. kind 0 runs predict
//   and update on the selected channel; kind 1 restarts it with the angle.
//   m_axis returns one result per item: tuser = {skipped, result_channel},
//   tdata = {estimated_bias, estimated_angle}.
//   The cfg port writes q_angle, q_bias and the measurement noise (index
//   0..2) and is always ready; the user must write only while idle, which
//   the block itself does not enforce. An update runs ten multiplies on the
//   one shared multiplier and, unless the innovation variance is zero, two
//   divides on the divider. Restart, skipped and bad-channel items use
//   neither. One item is in work at a time.
//   The result waits in an output register; the next item is taken while it
//   waits, but the block holds its next result until the receiver takes it.
//   Reset clears all angles, biases and covariances and loads the default
//   noise registers.
// ----------------------------------------------------------------------------
module angle_bias_kalman_filter #(
    parameter int CHANNELS  = kbf_pkg::CHANNELS_DEF,
    parameter int WORD_BITS = kbf_pkg::WORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // measured_angle, measured_rate, time_step
    input  logic [kbf_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
    // kind, channel
    input  logic [kbf_pkg::IN_USER_BITS-1:0]    s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // estimated_angle, estimated_bias
    output logic [kbf_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,
    // result_channel, skipped
    output logic [kbf_pkg::OUT_USER_BITS-1:0]   m_axis_tuser,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [kbf_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [kbf_pkg::CFG_BITS-1:0]        i_cfg_data
);

    localparam int W   = WORD_BITS;
    localparam int MW  = (W > 32) ? W : 32;
    localparam int OW  = MW + 1;
    localparam int AW  = MW + 3;
    localparam int CIW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int IOB = kbf_pkg::IO_BITS;
    localparam int TSB = kbf_pkg::TS_BITS;
    localparam logic signed [AW-1:0] LIM_HI = (AW'(1) <<< (W - 1)) - AW'(1);
    localparam logic signed [AW-1:0] LIM_LO = -LIM_HI - AW'(1);
    localparam logic signed [AW-1:0] O_HI   = AW'(2147483647);
    localparam logic signed [AW-1:0] O_LO   = -O_HI - AW'(1);

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_RATE, S_MISSUE, S_MWAIT, S_SUM, S_DISSUE, S_DWAIT, S_WB, S_OUT
    } t_state;

    typedef enum logic [3:0] {
        OP_ANG_PRED, OP_DP11, OP_P00, OP_P11, OP_ANG_UPD, OP_BIAS_UPD,
        OP_P00_UPD, OP_P01_UPD, OP_P10_UPD, OP_P11_UPD
    } t_op;

    function automatic logic signed [W-1:0] f_sat(input logic signed [AW-1:0] v);
        if (v > LIM_HI) begin
            return W'(LIM_HI);
        end else if (v < LIM_LO) begin
            return W'(LIM_LO);
        end
        return W'(v);
    endfunction

    function automatic logic signed [AW-1:0] f_ext(input logic signed [W-1:0] v);
        return AW'(v);
    endfunction

    function automatic logic [IOB-1:0] f_out32(input logic signed [W-1:0] x);
        logic signed [AW-1:0] v;
        v = AW'(x);
        if (v > O_HI) begin
            return 32'h7fffffff;
        end else if (v < O_LO) begin
            return 32'h80000000;
        end
        return v[IOB-1:0];
    endfunction

    // configuration
    logic [kbf_pkg::CFG_BITS-1:0] r_q_angle, r_q_bias, r_meas_noise;

    // per-channel state
    logic signed [W-1:0] r_ang_st  [CHANNELS];
    logic signed [W-1:0] r_bias_st [CHANNELS];
    logic signed [W-1:0] r_cov_st  [CHANNELS][4];

    // working set
    t_state              r_state;
    t_op                 r_op;
    logic                r_kind, r_ch;
    logic signed [IOB-1:0] r_meas, r_mrate;
    logic [TSB-1:0]      r_dt;
    logic signed [W-1:0] r_ang, r_bias, r_p0, r_p1, r_p2, r_p3;
    logic signed [W-1:0] r_rate, r_dp11, r_inner, r_s, r_k0, r_k1, r_y, r_p00t, r_p01t;
    logic signed [W-1:0] r_dn;
    logic                r_dsel;
    logic                r_div_start;
    kbf_pkg::t_mul_ctl   r_mctl;
    logic signed [OW-1:0] r_ma, r_mb;

    // result staging and output register
    logic [IOB-1:0]      r_res_ang, r_res_bias, r_o_ang, r_o_bias;
    logic                r_res_skip, r_o_skip, r_o_ch, r_o_valid;

    logic signed [OW-1:0] w_ma, w_mb;
    logic                 w_sh24;
    logic                 w_mul_done, w_div_done;
    logic signed [W-1:0]  w_m, w_q, w_s;
    logic signed [OW-1:0] w_dt_op;
    logic [CIW-1:0]       w_idx;
    logic                 w_ch_ok;
    logic                 w_bad_dt;

    assign w_dt_op  = OW'($signed({1'b0, r_dt}));
    assign w_idx    = CIW'(r_ch);
    assign w_ch_ok  = (32'(r_ch) < CHANNELS);
    assign w_bad_dt = (r_dt == '0) || (r_dt > kbf_pkg::ONE_SECOND);
    assign w_s      = f_sat(f_ext(r_p0) + AW'($signed({1'b0, r_meas_noise})));

    always_comb begin
        w_ma   = '0;
        w_mb   = '0;
        w_sh24 = 1'b1;
        case (r_op)
            OP_ANG_PRED: begin w_ma = w_dt_op; w_mb = OW'(r_rate);  w_sh24 = 1'b0; end
            OP_DP11:     begin w_ma = w_dt_op; w_mb = OW'(r_p3);    w_sh24 = 1'b0; end
            OP_P00:      begin w_ma = w_dt_op; w_mb = OW'(r_inner); w_sh24 = 1'b0; end
            OP_P11: begin
                w_ma   = OW'($signed({1'b0, r_q_bias}));
                w_mb   = w_dt_op;
                w_sh24 = 1'b0;
            end
            OP_ANG_UPD:  begin w_ma = OW'(r_k0); w_mb = OW'(r_y);    end
            OP_BIAS_UPD: begin w_ma = OW'(r_k1); w_mb = OW'(r_y);    end
            OP_P00_UPD:  begin w_ma = OW'(r_k0); w_mb = OW'(r_p00t); end
            OP_P01_UPD:  begin w_ma = OW'(r_k0); w_mb = OW'(r_p01t); end
            OP_P10_UPD:  begin w_ma = OW'(r_k1); w_mb = OW'(r_p00t); end
            OP_P11_UPD:  begin w_ma = OW'(r_k1); w_mb = OW'(r_p01t); end
            default: ;
        endcase
    end

    kbf_mul #(.WORD_BITS(W)) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (r_mctl),
        .i_a      (r_ma),
        .i_b      (r_mb),
        .o_done   (w_mul_done),
        .o_result (w_m)
    );

    kbf_div #(.WORD_BITS(W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_dn),
        .i_den   (r_s),
        .o_done  (w_div_done),
        .o_quot  (w_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_ANG_PRED;
            r_mctl      <= '0;
            r_div_start <= 1'b0;
            r_o_valid   <= 1'b0;
            r_q_angle    <= kbf_pkg::Q_ANGLE_RST;
            r_q_bias     <= kbf_pkg::Q_BIAS_RST;
            r_meas_noise <= kbf_pkg::MEAS_NOISE_RST;
            for (int c = 0; c < CHANNELS; c++) begin
                r_ang_st[c]  <= '0;
                r_bias_st[c] <= '0;
                for (int k = 0; k < 4; k++) begin
                    r_cov_st[c][k] <= '0;
                end
            end
        end else begin
            if (i_cfg_valid) begin
                case (kbf_pkg::t_cfg_idx'(i_cfg_index))
                    kbf_pkg::CFG_Q_ANGLE:    r_q_angle    <= i_cfg_data;
                    kbf_pkg::CFG_Q_BIAS:     r_q_bias     <= i_cfg_data;
                    kbf_pkg::CFG_MEAS_NOISE: r_meas_noise <= i_cfg_data;
                    default: ;
                endcase
            end

            // in S_OUT the output register is handled below
            if (m_axis_tready && (r_state != S_OUT)) begin
                r_o_valid <= 1'b0;
            end

            r_mctl.start <= (r_state == S_MISSUE);
            r_div_start  <= (r_state == S_DISSUE);

            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_kind  <= s_axis_tuser[0];
                        r_ch    <= s_axis_tuser[1];
                        r_meas  <= s_axis_tdata[IOB-1:0];
                        r_mrate <= s_axis_tdata[2*IOB-1:IOB];
                        r_dt    <= s_axis_tdata[2*IOB+TSB-1:2*IOB];
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (!w_ch_ok) begin
                        r_res_ang  <= '0;
                        r_res_bias <= '0;
                        r_res_skip <= 1'b1;
                        r_state    <= S_OUT;
                    end else if (r_kind) begin
                        // restart: load angle, clear bias and covariance
                        r_ang_st[w_idx]  <= f_sat(AW'(r_meas));
                        r_bias_st[w_idx] <= '0;
                        for (int k = 0; k < 4; k++) begin
                            r_cov_st[w_idx][k] <= '0;
                        end
                        r_res_ang  <= f_out32(f_sat(AW'(r_meas)));
                        r_res_bias <= '0;
                        r_res_skip <= 1'b0;
                        r_state    <= S_OUT;
                    end else if (w_bad_dt) begin
                        r_res_ang  <= f_out32(r_ang_st[w_idx]);
                        r_res_bias <= f_out32(r_bias_st[w_idx]);
                        r_res_skip <= 1'b1;
                        r_state    <= S_OUT;
                    end else begin
                        r_ang      <= r_ang_st[w_idx];
                        r_bias     <= r_bias_st[w_idx];
                        r_p0       <= r_cov_st[w_idx][0];
                        r_p1       <= r_cov_st[w_idx][1];
                        r_p2       <= r_cov_st[w_idx][2];
                        r_p3       <= r_cov_st[w_idx][3];
                        r_res_skip <= 1'b0;
                        r_state    <= S_RATE;
                    end
                end
                S_RATE: begin
                    r_rate  <= f_sat(AW'(r_mrate) - f_ext(r_bias));
                    r_op    <= OP_ANG_PRED;
                    r_state <= S_MISSUE;
                end
                S_MISSUE: begin
                    r_ma         <= w_ma;
                    r_mb         <= w_mb;
                    r_mctl.sh24  <= w_sh24;
                    r_state      <= S_MWAIT;
                end
                S_MWAIT: begin
                    if (w_mul_done) begin
                        case (r_op)
                            OP_ANG_PRED: begin
                                r_ang   <= f_sat(f_ext(r_ang) + f_ext(w_m));
                                r_op    <= OP_DP11;
                                r_state <= S_MISSUE;
                            end
                            OP_DP11: begin
                                r_dp11  <= w_m;
                                r_inner <= f_sat(f_ext(f_sat(f_ext(f_sat(f_ext(w_m)
                                           - f_ext(r_p1))) - f_ext(r_p2)))
                                           + AW'($signed({1'b0, r_q_angle})));
                                r_op    <= OP_P00;
                                r_state <= S_MISSUE;
                            end
                            OP_P00: begin
                                r_p0    <= f_sat(f_ext(r_p0) + f_ext(w_m));
                                r_p1    <= f_sat(f_ext(r_p1) - f_ext(r_dp11));
                                r_p2    <= f_sat(f_ext(r_p2) - f_ext(r_dp11));
                                r_op    <= OP_P11;
                                r_state <= S_MISSUE;
                            end
                            OP_P11: begin
                                r_p3    <= f_sat(f_ext(r_p3) + f_ext(w_m));
                                r_state <= S_SUM;
                            end
                            OP_ANG_UPD: begin
                                r_ang   <= f_sat(f_ext(r_ang) + f_ext(w_m));
                                r_op    <= OP_BIAS_UPD;
                                r_state <= S_MISSUE;
                            end
                            OP_BIAS_UPD: begin
                                r_bias  <= f_sat(f_ext(r_bias) + f_ext(w_m));
                                r_op    <= OP_P00_UPD;
                                r_state <= S_MISSUE;
                            end
                            OP_P00_UPD: begin
                                r_p0    <= f_sat(f_ext(r_p0) - f_ext(w_m));
                                r_op    <= OP_P01_UPD;
                                r_state <= S_MISSUE;
                            end
                            OP_P01_UPD: begin
                                r_p1    <= f_sat(f_ext(r_p1) - f_ext(w_m));
                                r_op    <= OP_P10_UPD;
                                r_state <= S_MISSUE;
                            end
                            OP_P10_UPD: begin
                                r_p2    <= f_sat(f_ext(r_p2) - f_ext(w_m));
                                r_op    <= OP_P11_UPD;
                                r_state <= S_MISSUE;
                            end
                            OP_P11_UPD: begin
                                r_p3    <= f_sat(f_ext(r_p3) - f_ext(w_m));
                                r_state <= S_WB;
                            end
                            default: r_state <= S_WB;
                        endcase
                    end
                end
                S_SUM: begin
                    r_s    <= w_s;
                    r_y    <= f_sat(AW'(r_meas) - f_ext(r_ang));
                    r_p00t <= r_p0;
                    r_p01t <= r_p1;
                    r_dsel <= 1'b0;
                    if (w_s == '0) begin
                        // zero innovation variance keeps the prediction
                        r_k0    <= '0;
                        r_k1    <= '0;
                        r_op    <= OP_ANG_UPD;
                        r_state <= S_MISSUE;
                    end else begin
                        r_state <= S_DISSUE;
                    end
                end
                S_DISSUE: begin
                    r_dn        <= r_dsel ? r_p2 : r_p0;
                    r_state     <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (w_div_done) begin
                        if (!r_dsel) begin
                            r_k0    <= w_q;
                            r_dsel  <= 1'b1;
                            r_state <= S_DISSUE;
                        end else begin
                            r_k1    <= w_q;
                            r_op    <= OP_ANG_UPD;
                            r_state <= S_MISSUE;
                        end
                    end
                end
                S_WB: begin
                    r_ang_st[w_idx]    <= r_ang;
                    r_bias_st[w_idx]   <= r_bias;
                    r_cov_st[w_idx][0] <= r_p0;
                    r_cov_st[w_idx][1] <= r_p1;
                    r_cov_st[w_idx][2] <= r_p2;
                    r_cov_st[w_idx][3] <= r_p3;
                    r_res_ang          <= f_out32(r_ang);
                    r_res_bias         <= f_out32(r_bias);
                    r_res_skip         <= 1'b0;
                    r_state            <= S_OUT;
                end
                S_OUT: begin
                    if (!r_o_valid || m_axis_tready) begin
                        r_o_valid <= 1'b1;
                        r_o_ang   <= r_res_ang;
                        r_o_bias  <= r_res_bias;
                        r_o_skip  <= r_res_skip;
                        r_o_ch    <= r_ch;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {r_o_bias, r_o_ang};
    assign m_axis_tuser  = {r_o_skip, r_o_ch};
    assign o_cfg_ready   = 1'b1;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("item accepted while the previous one is in work");

    a_mul_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> (r_state == S_MWAIT))
        else $error("multiplier finished outside its wait step");

    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DWAIT))
        else $error("divider finished outside its wait step");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && m_axis_tvalid && !m_axis_tready) |=> (r_state == S_OUT))
        else $error("result overwrote an output not yet taken");

endmodule

### dv/angle_bias_kalman_filter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angle_bias_kalman_filter_test
// Drives filter updates and restarts on both channels under random stalls on
// both streams. Each result is checked against a fixed-point angle/bias
// predictor kept in the bench, across several noise register settings.
// ----------------------------------------------------------------------------
module angle_bias_kalman_filter_test;

    localparam longint WMAX = 64'sd2147483647;
    localparam longint WMIN = -64'sd2147483648;
    localparam int LIMIT_CYCLES = 4000000;

    typedef struct {
        logic        ch;
        logic [31:0] angle;
        logic [31:0] bias;
        logic        skipped;
    } t_estimate;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    // measured_angle, measured_rate, time_step
    logic [kbf_pkg::IN_DATA_BITS-1:0] s_axis_tdata = '0;
    logic [kbf_pkg::IN_USER_BITS-1:0] s_axis_tuser = '0;   // kind, channel
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    // estimated_angle, estimated_bias
    logic [kbf_pkg::OUT_DATA_BITS-1:0] m_axis_tdata;
    logic [kbf_pkg::OUT_USER_BITS-1:0] m_axis_tuser;       // result_channel, skipped
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [kbf_pkg::CFG_IDX_BITS-1:0] i_cfg_index = '0;
    logic [kbf_pkg::CFG_BITS-1:0] i_cfg_data = '0;

    angle_bias_kalman_filter u_top (.*);

    always #10 i_clk = ~i_clk;

    // filter state mirrored in the bench
    longint angle_st[2];
    longint bias_st[2];
    longint cov_st[2][4];
    longint q_angle_r, q_bias_r, r_meas_r;

    t_estimate pending_estimates[$];
    int errors = 0;
    int cycles = 0;
    int tx_gap_max = 14;
    int rx_gap_max = 14;
    int rx_count = 0;

    function automatic longint sat_word(longint v);
        if (v > WMAX) return WMAX;
        if (v < WMIN) return WMIN;
        return v;
    endfunction

    function automatic longint from_mag(logic [127:0] m, bit neg);
        if (m > 128'(WMAX)) return neg ? WMIN : WMAX;
        return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    // product shifted right with rounding half away from zero
    function automatic longint mul_round(longint a, longint b, int sh);
        logic [127:0] m;
        longint ua, ub;
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        m = 128'(ua) * 128'(ub);
        m = (m + (128'd1 << (sh - 1))) >> sh;
        return from_mag(m, (a < 0) != (b < 0));
    endfunction

    // gain quotient with 24 fraction bits, truncated
    function automatic longint gain_div(longint n, longint d);
        logic [127:0] un, ud;
        bit neg;
        neg = (n < 0) != (d < 0);
        un = 128'((n < 0) ? -n : n);
        ud = 128'((d < 0) ? -d : d);
        if (un / ud > 128'(WMAX >>> 24)) return neg ? WMIN : WMAX;
        return from_mag((un << 24) / ud, neg);
    endfunction

    function automatic t_estimate predict_estimate(logic kind, logic ch, logic [31:0] meas_w,
                                                   logic [31:0] rate_w, logic [23:0] dt_w);
        t_estimate e;
        longint meas, ang, bias, rate, dt, dp11, inner, s, k0, k1, y, p00t, p01t;
        meas = longint'(signed'(meas_w));
        dt = longint'(dt_w);
        e.ch = ch;
        e.skipped = 1'b0;
        if (kind) begin
            angle_st[ch] = sat_word(meas);
            bias_st[ch] = 0;
            for (int i = 0; i < 4; i++) cov_st[ch][i] = 0;
            e.angle = angle_st[ch][31:0];
            e.bias = '0;
            return e;
        end
        if (dt_w == 0 || dt_w > kbf_pkg::ONE_SECOND) begin
            e.angle = angle_st[ch][31:0];
            e.bias = bias_st[ch][31:0];
            e.skipped = 1'b1;
            return e;
        end
        ang = angle_st[ch];
        bias = bias_st[ch];
        rate = sat_word(longint'(signed'(rate_w)) - bias);
        ang = sat_word(ang + mul_round(dt, rate, 23));
        dp11 = mul_round(dt, cov_st[ch][3], 23);
        inner = sat_word(sat_word(sat_word(dp11 - cov_st[ch][1]) - cov_st[ch][2]) + q_angle_r);
        cov_st[ch][0] = sat_word(cov_st[ch][0] + mul_round(dt, inner, 23));
        cov_st[ch][1] = sat_word(cov_st[ch][1] - dp11);
        cov_st[ch][2] = sat_word(cov_st[ch][2] - dp11);
        cov_st[ch][3] = sat_word(cov_st[ch][3] + mul_round(q_bias_r, dt, 23));
        s = sat_word(cov_st[ch][0] + r_meas_r);
        if (s == 0) begin
            k0 = 0;
            k1 = 0;
        end else begin
            k0 = gain_div(cov_st[ch][0], s);
            k1 = gain_div(cov_st[ch][2], s);
        end
        y = sat_word(meas - ang);
        ang = sat_word(ang + mul_round(k0, y, 24));
        bias = sat_word(bias + mul_round(k1, y, 24));
        p00t = cov_st[ch][0];
        p01t = cov_st[ch][1];
        cov_st[ch][0] = sat_word(cov_st[ch][0] - mul_round(k0, p00t, 24));
        cov_st[ch][1] = sat_word(cov_st[ch][1] - mul_round(k0, p01t, 24));
        cov_st[ch][2] = sat_word(cov_st[ch][2] - mul_round(k1, p00t, 24));
        cov_st[ch][3] = sat_word(cov_st[ch][3] - mul_round(k1, p01t, 24));
        angle_st[ch] = ang;
        bias_st[ch] = bias;
        e.angle = ang[31:0];
        e.bias = bias[31:0];
        return e;
    endfunction

    task automatic send_item(logic kind, logic ch, logic [31:0] meas, logic [31:0] rate,
                             logic [23:0] dt);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= {ch, kind};
        s_axis_tdata <= {dt, rate, meas};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_estimates.push_back(predict_estimate(kind, ch, meas, rate, dt));
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_estimates.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(kbf_pkg::t_cfg_idx idx, logic [31:0] value);
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            kbf_pkg::CFG_Q_ANGLE: q_angle_r = longint'(value);
            kbf_pkg::CFG_Q_BIAS: q_bias_r = longint'(value);
            default: r_meas_r = longint'(value);
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_restart_and_limits();
        send_item(1'b1, 1'b0, 32'h7fff_ffff, 32'h0, 24'h0);
        send_item(1'b1, 1'b1, 32'h8000_0000, 32'hffff_ffff, 24'hffffff);
        send_item(1'b0, 1'b0, 32'h8000_0000, 32'h7fff_ffff, kbf_pkg::ONE_SECOND);
        send_item(1'b0, 1'b1, 32'h7fff_ffff, 32'h8000_0000, kbf_pkg::ONE_SECOND);
        send_item(1'b0, 1'b0, 32'h0, 32'h0, 24'h1);
        send_item(1'b1, 1'b0, 32'h002d_0000, 32'h0, 24'h0);
        send_item(1'b0, 1'b0, 32'h002e_0000, 32'h0001_0000, 24'h002000);
        send_item(1'b0, 1'b1, 32'hffd3_0000, 32'hffff_0000, 24'h7fffff);
    endtask

    task automatic test_bad_time_step();
        send_item(1'b0, 1'b0, 32'h1234_5678, 32'h0000_1000, 24'h0);
        send_item(1'b0, 1'b1, 32'h1234_5678, 32'h0000_1000, kbf_pkg::ONE_SECOND + 24'd1);
        send_item(1'b0, 1'b0, 32'hedcb_a987, 32'hffff_f000, 24'hffffff);
    endtask

    task automatic test_register_extremes();
        // zero process and measurement noise after restart: innovation variance is zero
        write_reg(kbf_pkg::CFG_Q_ANGLE, 32'h0);
        write_reg(kbf_pkg::CFG_Q_BIAS, 32'h0);
        write_reg(kbf_pkg::CFG_MEAS_NOISE, 32'h0);
        send_item(1'b1, 1'b1, 32'h0010_0000, 32'h0, 24'h0);
        send_item(1'b0, 1'b1, 32'h0020_0000, 32'h0003_0000, 24'h020000);
        write_reg(kbf_pkg::CFG_Q_ANGLE, 32'hffff_ffff);
        write_reg(kbf_pkg::CFG_Q_BIAS, 32'hffff_ffff);
        write_reg(kbf_pkg::CFG_MEAS_NOISE, 32'hffff_ffff);
        send_item(1'b0, 1'b0, 32'h0050_0000, 32'h0002_0000, 24'h080000);
        send_item(1'b0, 1'b0, 32'hffb0_0000, 32'hfffe_0000, kbf_pkg::ONE_SECOND);
        send_item(1'b0, 1'b1, 32'h0000_8000, 32'h0000_0001, 24'h000800);
        write_reg(kbf_pkg::CFG_Q_ANGLE, kbf_pkg::Q_ANGLE_RST);
        write_reg(kbf_pkg::CFG_Q_BIAS, kbf_pkg::Q_BIAS_RST);
        write_reg(kbf_pkg::CFG_MEAS_NOISE, kbf_pkg::MEAS_NOISE_RST);
    endtask

    function automatic logic [31:0] rand_word(int full_pct, int span);
        if ($urandom_range(0, 99) < full_pct) return $urandom();
        return 32'($urandom_range(0, 2 * span) - span);
    endfunction

    task automatic test_random_tracking(int count);
        logic kind;
        logic [23:0] dt;
        int pick;
        for (int n = 0; n < count; n++) begin
            if (n % 150 == 0) begin
                pick = $urandom_range(0, 3);
                write_reg(kbf_pkg::CFG_Q_ANGLE,
                          pick == 0 ? $urandom() : $urandom_range(0, 200000));
                write_reg(kbf_pkg::CFG_Q_BIAS,
                          pick == 1 ? $urandom() : $urandom_range(0, 200000));
                write_reg(kbf_pkg::CFG_MEAS_NOISE,
                          pick == 2 ? $urandom() : $urandom_range(0, 2000000));
                tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
                rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
            end
            if (n == count / 2) wait_drained();
            pick = $urandom_range(0, 99);
            kind = (pick < 5);
            if (pick < 10) dt = ($urandom_range(0, 1) == 0) ? 24'h0
                                : 24'($urandom_range(kbf_pkg::ONE_SECOND + 1, 24'hffffff));
            else if (pick < 75) dt = 24'($urandom_range(1, 24'h020000));
            else dt = 24'($urandom_range(1, kbf_pkg::ONE_SECOND));
            send_item(kind, 1'($urandom()), rand_word(5, 32'h00b4_0000),
                      rand_word(5, 32'h01f4_0000), dt);
        end
    endtask

    // result checker, and receiver stall drawn once per transaction
    always @(posedge i_clk) begin
        t_estimate e;
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("angle_bias_kalman_filter_test NOT OK");
            $finish;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            rx_count++;
            if (pending_estimates.size() == 0) begin
                $display("%0t: unexpected result tuser=%h tdata=%h", $time,
                         m_axis_tuser, m_axis_tdata);
                errors++;
            end else begin
                e = pending_estimates.pop_front();
                if (m_axis_tuser[0] !== e.ch) begin
                    $display("%0t: channel exp %0d act %0d", $time, e.ch, m_axis_tuser[0]);
                    errors++;
                end
                if (m_axis_tuser[1] !== e.skipped) begin
                    $display("%0t: skipped exp %0d act %0d", $time, e.skipped, m_axis_tuser[1]);
                    errors++;
                end
                if (m_axis_tdata[31:0] !== e.angle) begin
                    $display("%0t: angle exp %h act %h", $time, e.angle, m_axis_tdata[31:0]);
                    errors++;
                end
                if (m_axis_tdata[63:32] !== e.bias) begin
                    $display("%0t: bias exp %h act %h", $time, e.bias, m_axis_tdata[63:32]);
                    errors++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        static int seen = 0;
        static int hold = 0;
        if (seen != rx_count) begin
            seen = rx_count;
            hold = $urandom_range(0, rx_gap_max);
        end
        if (hold > 0) begin
            m_axis_tready <= 1'b0;
            hold--;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        for (int c = 0; c < 2; c++) begin
            angle_st[c] = 0;
            bias_st[c] = 0;
            for (int i = 0; i < 4; i++) cov_st[c][i] = 0;
        end
        q_angle_r = longint'(kbf_pkg::Q_ANGLE_RST);
        q_bias_r = longint'(kbf_pkg::Q_BIAS_RST);
        r_meas_r = longint'(kbf_pkg::MEAS_NOISE_RST);
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_restart_and_limits();
        test_bad_time_step();
        test_register_extremes();
        test_random_tracking(1330);
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("angle_bias_kalman_filter_test OK");
        end else begin
            $display("angle_bias_kalman_filter_test NOT OK");
        end
        $finish;
    end

endmodule

### angle_bias_kalman_filter.f
rtl/kbf_pkg.sv
rtl/kbf_mul.sv
rtl/kbf_div.sv
rtl/angle_bias_kalman_filter.sv
dv/angle_bias_kalman_filter_test.sv
